### hw/rtl/cle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg - console line editor shared definitions
// Character codes, job and result word types, and the small tables that turn a
// job into its sequence of transmit and report words.
// ----------------------------------------------------------------------------
package cle_pkg;

	// default line capacity; the line holds one character less than this
	localparam int LINE_CAPACITY_DEF = 128;

	// widths of the result fields
	localparam int LEN_W  = 7;
	localparam int CMD_W  = 3;
	localparam int STEP_W = 4;

	// leading characters kept for command matching
	localparam int HEAD_LEN = 6;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// character codes
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_UC_A  = 8'd65;
	localparam logic [7:0] CH_UC_Z  = 8'd90;

	// input opcodes
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// result kinds
	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_HELP       = 3'd0,
		CMD_INFO       = 3'd1,
		CMD_STATUS     = 3'd2,
		CMD_RESET      = 3'd3,
		CMD_ECHO_TEXT  = 3'd4,
		CMD_ECHO_EMPTY = 3'd5,
		CMD_UNKNOWN    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		JOB_ECHO,
		JOB_ERASE,
		JOB_LINE,
		JOB_FULL
	} job_op_t;

	// one unit of work handed from front to back
	typedef struct packed {
		job_op_t          op;
		logic [7:0]       data;
		cmd_t             cmd;
		logic [LEN_W-1:0] len;
	} job_t;

	// one result word
	typedef struct packed {
		logic             kind;
		logic [7:0]       tx;
		logic [CMD_W-1:0] cmd;
		logic [LEN_W-1:0] len;
		logic             last;
	} word_t;

	// fold A..Z to lower case
	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	// index of the final word of a job
	function automatic logic [STEP_W-1:0] job_last_step(input job_op_t op);
		logic [STEP_W-1:0] n;
		case (op)
			JOB_ECHO:  n = 4'd0;
			JOB_ERASE: n = 4'd2;
			JOB_LINE:  n = 4'd2;
			JOB_FULL:  n = 4'd15;
			default:   n = 4'd0;
		endcase
		return n;
	endfunction

	// CR LF "Buffer full!" CR LF
	function automatic logic [7:0] full_msg_byte(input logic [STEP_W-1:0] i);
		logic [7:0] b;
		case (i)
			4'd0:    b = CH_CR;
			4'd1:    b = CH_LF;
			4'd2:    b = "B";
			4'd3:    b = "u";
			4'd4:    b = "f";
			4'd5:    b = "f";
			4'd6:    b = "e";
			4'd7:    b = "r";
			4'd8:    b = " ";
			4'd9:    b = "f";
			4'd10:   b = "u";
			4'd11:   b = "l";
			4'd12:   b = "l";
			4'd13:   b = "!";
			4'd14:   b = CH_CR;
			4'd15:   b = CH_LF;
			default: b = CH_CR;
		endcase
		return b;
	endfunction

	// result word number i of a job
	function automatic word_t job_word(input job_t j, input logic [STEP_W-1:0] i);
		word_t w;
		w = '0;
		case (j.op)
			JOB_ECHO: begin
				w.tx = j.data;
			end
			JOB_ERASE: begin
				w.tx = (i == 4'd1) ? CH_SP : CH_BS;
			end
			JOB_LINE: begin
				if (i == 4'd0) begin
					w.tx = CH_CR;
				end else if (i == 4'd1) begin
					w.tx = CH_LF;
				end else begin
					w.kind = KIND_REPORT;
					w.cmd  = j.cmd;
					w.len  = j.len;
				end
			end
			JOB_FULL: begin
				w.tx = full_msg_byte(i);
			end
			default: begin
				w.tx = 8'd0;
			end
		endcase
		w.last = (i == job_last_step(j.op));
		return w;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/cle_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_front - input side of the console line editor
// Takes one received word per cycle unless stalled, keeps the fill count and
// the leading line characters, matches commands, queues jobs for the back end.
// ----------------------------------------------------------------------------
module cle_front #(
	parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  wire logic         opcode,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         q_full,
	output logic              push,
	output cle_pkg::job_t     push_job
);

	localparam int FILL_W = $clog2(LINE_CAPACITY);
	localparam int LW     = cle_pkg::LEN_W;
	localparam int HL     = cle_pkg::HEAD_LEN;

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_nxt;
	logic [7:0]        head_q [HL];
	logic [7:0]        f [HL];
	logic              accept;
	logic              store;
	cle_pkg::cmd_t     cmd;

	// hold the input whenever the job queue has no room
	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	// match the completed line against the known commands
	always_comb begin
		for (int i = 0; i < HL; i++) begin
			f[i] = cle_pkg::fold(head_q[i]);
		end
		if (fill_q == FILL_W'(4) && f[0] == "h" && f[1] == "e" && f[2] == "l"
				&& f[3] == "p") begin
			cmd = cle_pkg::CMD_HELP;
		end else if (fill_q == FILL_W'(4) && f[0] == "i" && f[1] == "n"
				&& f[2] == "f" && f[3] == "o") begin
			cmd = cle_pkg::CMD_INFO;
		end else if (fill_q == FILL_W'(6) && f[0] == "s" && f[1] == "t"
				&& f[2] == "a" && f[3] == "t" && f[4] == "u" && f[5] == "s") begin
			cmd = cle_pkg::CMD_STATUS;
		end else if (fill_q == FILL_W'(5) && f[0] == "r" && f[1] == "e"
				&& f[2] == "s" && f[3] == "e" && f[4] == "t") begin
			cmd = cle_pkg::CMD_RESET;
		end else if (fill_q >= FILL_W'(5) && f[0] == "e" && f[1] == "c"
				&& f[2] == "h" && f[3] == "o" && f[4] == " ") begin
			cmd = (fill_q > FILL_W'(5)) ? cle_pkg::CMD_ECHO_TEXT
				: cle_pkg::CMD_ECHO_EMPTY;
		end else begin
			cmd = cle_pkg::CMD_UNKNOWN;
		end
	end

	// classify the word and build the job
	always_comb begin
		push          = 1'b0;
		store         = 1'b0;
		fill_nxt      = fill_q;
		push_job.op   = cle_pkg::JOB_ECHO;
		push_job.data = rx_byte;
		push_job.cmd  = cmd;
		push_job.len  = LW'(fill_q);
		if (accept) begin
			if (opcode == cle_pkg::OP_FLUSH) begin
				fill_nxt = '0;
			end else begin
				case (rx_byte) inside
					cle_pkg::CH_LF, cle_pkg::CH_CR: begin
						if (fill_q != '0) begin
							push        = 1'b1;
							push_job.op = cle_pkg::JOB_LINE;
							fill_nxt    = '0;
						end
					end
					cle_pkg::CH_BS, cle_pkg::CH_DEL: begin
						if (fill_q != '0) begin
							push        = 1'b1;
							push_job.op = cle_pkg::JOB_ERASE;
							fill_nxt    = fill_q - FILL_W'(1);
						end
					end
					[cle_pkg::CH_SP:cle_pkg::CH_TILDE]: begin
						push = 1'b1;
						if (fill_q != FILL_W'(LINE_CAPACITY - 1)) begin
							store    = 1'b1;
							fill_nxt = fill_q + FILL_W'(1);
						end else begin
							push_job.op = cle_pkg::JOB_FULL;
							fill_nxt    = '0;
						end
					end
					default: begin
						fill_nxt = fill_q;
					end
				endcase
			end
		end
	end

	// advance the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_nxt;
		end
	end

	// capture the leading characters of the line
	always_ff @(posedge clk) begin
		for (int i = 0; i < HL; i++) begin
			if (store && fill_q == FILL_W'(i)) begin
				head_q[i] <= rx_byte;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_CAPACITY - 1))
		else $error("fill count beyond line capacity");

	a_push_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept && opcode == cle_pkg::OP_BYTE)
		else $error("job queued without an accepted byte");

endmodule
`default_nettype wire

### hw/rtl/cle_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_queue - job queue between front and back of the line editor
// Small register FIFO so that the front can take a word while the back end is
// still sending the results of an earlier one.
// ----------------------------------------------------------------------------
module cle_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cle_pkg::job_t push_job,
	input  wire logic          pop,
	output logic               full,
	output logic               head_valid,
	output cle_pkg::job_t      head_job
);

	localparam int AW    = cle_pkg::QUEUE_AW;
	localparam int DEPTH = cle_pkg::QUEUE_DEPTH;

	cle_pkg::job_t  slot_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;

	assign full       = (count_q == (AW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	// write the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job popped from an empty queue");

endmodule
`default_nettype wire

### hw/rtl/cle_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_back - output side of the line editor
// Takes one job at a time from the queue and sends its words, one per cycle
// unless the result is stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module cle_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire cle_pkg::job_t head_job,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_stall,
	output cle_pkg::word_t     result_word
);

	localparam int SW = cle_pkg::STEP_W;

	cle_pkg::job_t   cur_q;
	logic            active_q;
	logic [SW-1:0]   step_q;
	logic            result_valid_q;
	cle_pkg::word_t  word_q;
	logic            emit;
	logic            done;

	// step through the current job while the output register has room
	assign emit = active_q && (!result_valid_q || !result_stall);
	assign done = emit && (step_q == cle_pkg::job_last_step(cur_q.op));
	assign pop  = head_valid && (!active_q || done);

	assign result_valid = result_valid_q;
	assign result_word  = word_q;

	// load the next job or advance the step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			step_q   <= '0;
		end else if (done) begin
			active_q <= 1'b0;
		end else if (emit) begin
			step_q <= step_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_job;
		end
	end

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= cle_pkg::job_word(cur_q, step_q);
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> step_q <= cle_pkg::job_last_step(cur_q.op))
		else $error("step past the end of the job");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_stall |=> result_valid_q && $stable(word_q))
		else $error("stalled result word changed");

endmodule
`default_nettype wire

### hw/rtl/console_line_editor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_editor_core - serial console line editor
// Edits a console line from received bytes, echoes and erases characters,
// reports a full line and matches completed lines against known commands.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_stall    opcode, rx_byte
//   result   out        result_valid / result_stall kind, tx_byte, command,
//                                                  line_length, last
//
// The front takes one word per cycle while the two-entry job queue has room.
// The back end sets the sustained rate: one result word per cycle unless
// stalled. A byte yields one word, erase or line end three, full line sixteen.
// Reset clears the fill count, queue and output register; line characters are
// not cleared. A result stall holds the output register, then fills the queue,
// then stalls the input.
// ----------------------------------------------------------------------------
module console_line_editor_core #(
	parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic                        opcode,
	input  wire logic [7:0]                  rx_byte,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic                             kind,
	output logic [7:0]                       tx_byte,
	output logic [cle_pkg::CMD_W-1:0]        command,
	output logic [cle_pkg::LEN_W-1:0]        line_length,
	output logic                             last
);

	logic            q_full;
	logic            push;
	cle_pkg::job_t   push_job;
	logic            pop;
	logic            head_valid;
	cle_pkg::job_t   head_job;
	cle_pkg::word_t  word;

	cle_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	cle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	cle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (word)
	);

	// unpack the result word onto the ports
	assign kind        = word.kind;
	assign tx_byte     = word.tx;
	assign command     = word.cmd;
	assign line_length = word.len;
	assign last        = word.last;

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - console line editor core testbench
// Replays a short script of edge cases, then typed command lines, noise,
// broken edits and two full-length lines. Random sender bursts and receiver
// stalls are applied throughout. Every result word is checked against a line
// editor predictor kept inside this bench or, for echo rows, a script literal.
// ----------------------------------------------------------------------------
module tb;
	import cle_pkg::*;

	localparam int LINE_MAX    = LINE_CAPACITY_DEF - 1;
	localparam int ITEM_TARGET = 470;
	localparam int HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP   = 20;

	// how a script row gets its expectation
	typedef enum logic [1:0] {
		CHK_PRED,
		CHK_SILENT,
		CHK_ECHO
	} chk_t;

	typedef struct packed {
		logic       op;
		logic [7:0] c;
		chk_t       chk;
		logic [7:0] tx_lit;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic                   opcode = OP_BYTE;
	logic [7:0]             rx_byte = 8'd0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic                   kind;
	logic [7:0]             tx_byte;
	logic [CMD_W-1:0]       command;
	logic [LEN_W-1:0]       line_length;
	logic                   last;

	// predictor state
	logic [7:0] line_chars [0:LINE_MAX-1];
	int         line_fill = 0;
	word_t      pending_words [$];

	// bookkeeping
	int items_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int reports_made = 0;
	int full_msgs = 0;
	int cycle_count = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int burst_left = 0;
	bit steady = 1'b0;

	// directed script: edge cases first, then a command and an empty echo
	row_t script [0:24] = '{
		'{OP_BYTE,  CH_CR,    CHK_SILENT, 8'd0},
		'{OP_BYTE,  CH_LF,    CHK_SILENT, 8'd0},
		'{OP_BYTE,  CH_BS,    CHK_SILENT, 8'd0},
		'{OP_BYTE,  CH_DEL,   CHK_SILENT, 8'd0},
		'{OP_BYTE,  8'h00,    CHK_SILENT, 8'd0},
		'{OP_BYTE,  8'hFF,    CHK_SILENT, 8'd0},
		'{OP_BYTE,  8'h80,    CHK_SILENT, 8'd0},
		'{OP_FLUSH, 8'h55,    CHK_SILENT, 8'd0},
		'{OP_BYTE,  CH_SP,    CHK_ECHO,   CH_SP},
		'{OP_BYTE,  CH_TILDE, CHK_ECHO,   CH_TILDE},
		'{OP_BYTE,  CH_DEL,   CHK_PRED,   8'd0},
		'{OP_BYTE,  CH_BS,    CHK_PRED,   8'd0},
		'{OP_BYTE,  "H",      CHK_PRED,   8'd0},
		'{OP_BYTE,  "e",      CHK_PRED,   8'd0},
		'{OP_BYTE,  "L",      CHK_PRED,   8'd0},
		'{OP_BYTE,  "p",      CHK_PRED,   8'd0},
		'{OP_BYTE,  CH_CR,    CHK_PRED,   8'd0},
		'{OP_BYTE,  "x",      CHK_PRED,   8'd0},
		'{OP_FLUSH, 8'hAA,    CHK_PRED,   8'd0},
		'{OP_BYTE,  "e",      CHK_PRED,   8'd0},
		'{OP_BYTE,  "C",      CHK_PRED,   8'd0},
		'{OP_BYTE,  "h",      CHK_PRED,   8'd0},
		'{OP_BYTE,  "O",      CHK_PRED,   8'd0},
		'{OP_BYTE,  CH_SP,    CHK_PRED,   8'd0},
		'{OP_BYTE,  CH_LF,    CHK_PRED,   8'd0}
	};

	console_line_editor_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.tx_byte      (tx_byte),
		.command      (command),
		.line_length  (line_length),
		.last         (last)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Line editor predictor
	// ------------------------------------------------------------------

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// leading characters of the line equal w, ignoring case
	function automatic bit head_is(input string w);
		int i;
		if (line_fill < w.len()) return 1'b0;
		for (i = 0; i < w.len(); i++) begin
			if (lower(line_chars[i]) != w[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic cmd_t match_command();
		if (line_fill == 4 && head_is("help")) return CMD_HELP;
		if (line_fill == 4 && head_is("info")) return CMD_INFO;
		if (line_fill == 6 && head_is("status")) return CMD_STATUS;
		if (line_fill == 5 && head_is("reset")) return CMD_RESET;
		if (head_is("echo ")) return (line_fill > 5) ? CMD_ECHO_TEXT : CMD_ECHO_EMPTY;
		return CMD_UNKNOWN;
	endfunction

	function automatic word_t tx_word(input logic [7:0] c);
		word_t w;
		w = '0;
		w.kind = KIND_TX;
		w.tx = c;
		return w;
	endfunction

	// apply one input word to the line; queue its results when keep is set
	function automatic void edit_line(input logic op, input logic [7:0] c, input bit keep);
		word_t made [$];
		word_t rep;
		string banner;
		int i;
		banner = "Buffer full!";
		if (op == OP_FLUSH) begin
			line_fill = 0;
			return;
		end
		if (c == CH_CR || c == CH_LF) begin
			if (line_fill == 0) return;
			made.push_back(tx_word(CH_CR));
			made.push_back(tx_word(CH_LF));
			rep = '0;
			rep.kind = KIND_REPORT;
			rep.cmd = match_command();
			rep.len = LEN_W'(line_fill);
			made.push_back(rep);
			reports_made++;
			line_fill = 0;
		end else if (c == CH_BS || c == CH_DEL) begin
			if (line_fill == 0) return;
			line_fill--;
			made.push_back(tx_word(CH_BS));
			made.push_back(tx_word(CH_SP));
			made.push_back(tx_word(CH_BS));
		end else if (c >= CH_SP && c <= CH_TILDE) begin
			if (line_fill < LINE_MAX) begin
				line_chars[line_fill] = c;
				line_fill++;
				made.push_back(tx_word(c));
			end else begin
				// drop the line and send the full-line notice
				made.push_back(tx_word(CH_CR));
				made.push_back(tx_word(CH_LF));
				for (i = 0; i < banner.len(); i++) begin
					made.push_back(tx_word(banner[i]));
				end
				made.push_back(tx_word(CH_CR));
				made.push_back(tx_word(CH_LF));
				full_msgs++;
				line_fill = 0;
			end
		end
		if (made.size() == 0) return;
		made[made.size() - 1].last = 1'b1;
		if (keep) begin
			foreach (made[j]) pending_words.push_back(made[j]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("[%0t] result word %0d: %s got 0x%0h, want 0x%0h",
				$time, results_checked, what, got, want);
		end
	endtask

	word_t want_word;

	// compare every accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word, tx_byte", tx_byte, 0);
			end else begin
				want_word = pending_words.pop_front();
				if (kind !== want_word.kind) report_mismatch("kind", kind, want_word.kind);
				if (tx_byte !== want_word.tx) report_mismatch("tx_byte", tx_byte, want_word.tx);
				if (command !== want_word.cmd) report_mismatch("command", command, want_word.cmd);
				if (line_length !== want_word.len)
					report_mismatch("line_length", line_length, want_word.len);
				if (last !== want_word.last) report_mismatch("last", last, want_word.last);
			end
			results_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall segments, plus long hold-offs on request
	// ------------------------------------------------------------------

	int seg_left = 0;
	int stall_pct = 0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (holds_done != hold_requests) begin
			holds_done = holds_done + 1;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(5, 80);
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2:    stall_pct = 20;
					3:    stall_pct = 50;
					default: stall_pct = 80;
				endcase
			end else begin
				seg_left = seg_left - 1;
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// offer one word, idling between bursts unless steady is set
	task automatic offer_word(input logic op, input logic [7:0] c, input bit keep);
		int gap;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		item_valid <= 1'b1;
		opcode <= op;
		rx_byte <= c;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		edit_line(op, c, keep);
		items_sent++;
	endtask

	task automatic type_random(input int n);
		repeat (n) offer_word(OP_BYTE, 8'($urandom_range(32, 126)), 1'b1);
	endtask

	// type a word in random case, with the odd typo erased again
	task automatic type_word(input string w, input bit messy);
		int k;
		logic [7:0] c;
		for (k = 0; k < w.len(); k++) begin
			if (messy && $urandom_range(0, 7) == 0) begin
				offer_word(OP_BYTE, 8'($urandom_range(32, 126)), 1'b1);
				offer_word(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL, 1'b1);
			end
			c = w[k];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
			offer_word(OP_BYTE, c, 1'b1);
		end
	endtask

	task automatic end_line();
		offer_word(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, 1'b1);
	endtask

	task automatic type_command();
		case ($urandom_range(0, 10))
			0: type_word("help", 1'b1);
			1: type_word("info", 1'b1);
			2: type_word("status", 1'b1);
			3: type_word("reset", 1'b1);
			4: begin
				type_word("echo ", 1'b1);
				type_random($urandom_range(1, 10));
			end
			5: type_word("echo ", 1'b1);
			6: type_word("echo", 1'b1);
			7: type_word("hel", 1'b1);
			8: type_word("helpx", 1'b1);
			9: type_word("status ", 1'b1);
			default: type_random($urandom_range(1, 12));
		endcase
		end_line();
	endtask

	// partial lines cut by a flush, runs of erases, line ends on empty lines
	task automatic type_broken();
		case ($urandom_range(0, 2))
			0: begin
				type_random($urandom_range(1, 6));
				offer_word(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b1);
			end
			1: begin
				type_random($urandom_range(1, 3));
				repeat ($urandom_range(2, 6))
					offer_word(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL, 1'b1);
			end
			default: begin
				type_word("info", 1'b0);
				end_line();
				end_line();
			end
		endcase
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			offer_word($urandom_range(0, 7) == 0 ? OP_FLUSH : OP_BYTE,
				8'($urandom_range(0, 255)), 1'b1);
	endtask

	// hold until every expected word has come back
	task automatic drain();
		item_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// stall the receiver while a line streams in at full rate
	task automatic squeeze();
		hold_requests++;
		steady = 1'b1;
		type_random(12);
		end_line();
		steady = 1'b0;
	endtask

	initial begin : main
		int i;
		bit mid_done;
		mid_done = 1'b0;

		// reset once
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script
		for (i = 0; i < 25; i++) begin
			if (script[i].chk == CHK_ECHO) begin
				pending_words.push_back(tx_word(script[i].tx_lit));
				pending_words[pending_words.size() - 1].last = 1'b1;
			end
			offer_word(script[i].op, script[i].c, script[i].chk == CHK_PRED);
		end
		drain();
		squeeze();

		// longest line reported, then a line that overflows
		type_random(LINE_MAX);
		end_line();
		type_random(LINE_MAX + 1);

		// random part
		while (items_sent < ITEM_TARGET) begin
			if (!mid_done && items_sent >= 380) begin
				mid_done = 1'b1;
				drain();
				squeeze();
			end
			i = $urandom_range(0, 99);
			if (i < 60) type_command();
			else if (i < 75) type_broken();
			else if (i < 90) send_noise();
			else begin
				type_random($urandom_range(1, 30));
				end_line();
			end
		end

		// wait out the last words and any stray output
		drain();
		repeat (40) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch("words never received, count", 0, pending_words.size());

		$display("Sent %0d input words; checked %0d result words.", items_sent,
			results_checked);
		$display("Lines reported: %0d; full-line notices: %0d; mismatches: %0d.",
			reports_made, full_msgs, mismatches);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/cle_pkg.sv
hw/rtl/cle_front.sv
hw/rtl/cle_queue.sv
hw/rtl/cle_back.sv
hw/rtl/console_line_editor_core.sv
bench/tb.sv
